>>> rtl/core/hbs_pkg.sv
// Shared types, command codes and the per-byte bit stuffing function for the
// HDLC bit stuffing encoder. No dependencies.
package hbs_pkg;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [2:0] STUFF_RUN = 3'd5;

  typedef struct packed {
    logic [2:0] ones_run;
    logic [2:0] bit_fill;
    logic [7:0] partial_bits;
  } enc_state_t;

  typedef struct packed {
    logic [1:0] count;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last0;
    logic       last1;
  } out_pair_t;

  typedef struct packed {
    logic [9:0] bits;
    logic [3:0] len;
    logic [2:0] run;
  } stuff_t;

  function automatic stuff_t stuff_byte(input logic [7:0] d, input logic [2:0] run_in);
    stuff_t     r;
    logic [9:0] v;
    logic [3:0] n;
    logic [2:0] run;
    v   = '0;
    n   = 4'd0;
    run = run_in;
    for (int i = 7; i >= 0; i--) begin
      v = {v[8:0], d[i]};
      n = n + 4'd1;
      if (d[i]) begin
        run = run + 3'd1;
      end else begin
        run = 3'd0;
      end
      if (run >= STUFF_RUN) begin
        run = 3'd0;
        v   = {v[8:0], 1'b0};
        n   = n + 4'd1;
      end
    end
    r.bits = v << (4'd10 - n);
    r.len  = n;
    r.run  = run;
    return r;
  endfunction

endpackage

>>> rtl/core/hbs_bit_stuff_encoder_unit.sv
// Top level of the HDLC bit stuffing encoder: input register, encoder
// state, stuffing step and result buffer. Uses hbs_pkg, hbs_stuff, hbs_out_buf.
//
// Input channel: in_valid / in_stall with cmd and data_byte. cmd start emits
// the flag 0x7E and clears the state, data stuffs one byte MSB first, end
// appends the closing flag, pads to a byte and marks the final byte with
// frame_last. Command 3 is dropped without results.
// Output channel: out_valid / out_stall with out_byte and frame_last; one
// byte per cycle while out_stall is low, zero to two bytes per item.
// The first byte of an item passes through the input register and the
// result buffer before it is shown on out_byte.
// Throughput: one item per cycle while items give at most one byte each
// and the receiver does not stall; an item that gives two bytes holds the
// next until the single output port drains the two-entry buffer to one byte.
// Reset: rst clears the stuffing state, the input register and the buffer.
// When the receiver stalls, the buffered byte holds, the next item waits in
// the input register and in_stall rises once that register is occupied.
module hdlc_bit_stuff_encoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       frame_last
);

  logic                held;
  logic [1:0]          cmd_q;
  logic [7:0]          data_q;
  hbs_pkg::enc_state_t st;
  hbs_pkg::enc_state_t st_next;
  hbs_pkg::out_pair_t  res;
  logic                can_load;
  logic                load;

  assign load     = held && can_load;
  assign in_stall = held && !can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_q  <= cmd;
      data_q <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (load) begin
      st <= st_next;
    end
  end

  hbs_stuff u_stuff (
    .cmd       (cmd_q),
    .data_byte (data_q),
    .st        (st),
    .res       (res),
    .st_next   (st_next)
  );

  hbs_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .res        (res),
    .out_stall  (out_stall),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .frame_last (frame_last)
  );

endmodule

>>> rtl/core/hbs_stuff.sv
// Combinational step of the encoder: stuffs one item, merges it with the
// pending bits and yields up to two output bytes and the next state. Uses hbs_pkg.
module hbs_stuff (
  input  logic [1:0]         cmd,
  input  logic [7:0]         data_byte,
  input  hbs_pkg::enc_state_t st,
  output hbs_pkg::out_pair_t  res,
  output hbs_pkg::enc_state_t st_next
);

  hbs_pkg::stuff_t sf;
  logic [9:0]      seq;
  logic [3:0]      slen;
  logic [23:0]     acc;
  logic [4:0]      total;

  always_comb begin
    sf = hbs_pkg::stuff_byte(data_byte, st.ones_run);
    if (cmd == hbs_pkg::CMD_END) begin
      seq  = {hbs_pkg::FLAG_BYTE, 2'b00};
      slen = 4'd8;
    end else begin
      seq  = sf.bits;
      slen = sf.len;
    end
    acc   = {st.partial_bits, 16'h0000} | ({seq, 14'h0000} >> st.bit_fill);
    total = {2'b00, st.bit_fill} + {1'b0, slen};

    res     = '0;
    st_next = st;
    unique case (cmd)
      hbs_pkg::CMD_START: begin
        res.count = 2'd1;
        res.b0    = hbs_pkg::FLAG_BYTE;
        st_next   = '0;
      end
      hbs_pkg::CMD_DATA: begin
        res.count = total[4:3];
        res.b0    = acc[23:16];
        res.b1    = acc[15:8];
        st_next.ones_run = sf.run;
        st_next.bit_fill = total[2:0];
        unique case (total[4:3])
          2'd0:    st_next.partial_bits = acc[23:16];
          2'd1:    st_next.partial_bits = acc[15:8];
          default: st_next.partial_bits = acc[7:0];
        endcase
      end
      hbs_pkg::CMD_END: begin
        res.b0 = acc[23:16];
        res.b1 = acc[15:8];
        if (st.bit_fill == 3'd0) begin
          res.count = 2'd1;
          res.last0 = 1'b1;
        end else begin
          res.count = 2'd2;
          res.last1 = 1'b1;
        end
        st_next = '0;
      end
      default: begin
        res     = '0;
        st_next = st;
      end
    endcase
  end

endmodule

>>> rtl/core/hbs_out_buf.sv
// Two-entry result buffer: holds the bytes of one item and presents them
// one per cycle while out_stall is low on the output channel. Uses hbs_pkg.
module hbs_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  hbs_pkg::out_pair_t res,
  input  logic               out_stall,
  output logic               can_load,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               frame_last
);

  hbs_pkg::out_pair_t pair;
  logic [1:0]         rem;
  logic               head;

  assign out_valid  = (rem != 2'd0);
  assign out_byte   = head ? pair.b1 : pair.b0;
  assign frame_last = head ? pair.last1 : pair.last0;
  assign can_load   = (rem == 2'd0) || ((rem == 2'd1) && !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem  <= 2'd0;
      head <= 1'b0;
    end else if (load) begin
      rem  <= res.count;
      head <= 1'b0;
    end else if (out_valid && !out_stall) begin
      rem  <= rem - 2'd1;
      head <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pair <= res;
    end
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for hdlc_bit_stuff_encoder_unit: frames of start, data and end
// items are predicted bit by bit and every output byte is compared in order.
// Depends on hbs_pkg and the encoder RTL only.
module tb_top;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } enc_byte_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       frame_last;

  enc_byte_t  expected_bytes[$];
  logic [2:0] run_len;
  logic [2:0] fill;
  logic [7:0] pending;

  bit quiet;
  bit hold_req;
  int errors;
  int bytes_checked;
  int frames_closed;
  int aligned_closes;
  int stuffed_zeros;
  int input_stall_cycles;

  hdlc_bit_stuff_encoder_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .frame_last (frame_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic shift_in_bit(input logic b);
    enc_byte_t full;
    if (b) begin
      pending[3'd7 - fill] = 1'b1;
    end
    if (fill == 3'd7) begin
      full.value = pending;
      full.last  = 1'b0;
      expected_bytes.push_back(full);
      fill    = 3'd0;
      pending = 8'h00;
    end else begin
      fill = fill + 3'd1;
    end
  endtask

  task automatic clear_encoder();
    run_len = 3'd0;
    fill    = 3'd0;
    pending = 8'h00;
  endtask

  task automatic encode_item(input logic [1:0] c, input logic [7:0] d);
    enc_byte_t eb;
    case (c)
      hbs_pkg::CMD_START: begin
        clear_encoder();
        eb.value = hbs_pkg::FLAG_BYTE;
        eb.last  = 1'b0;
        expected_bytes.push_back(eb);
      end
      hbs_pkg::CMD_DATA: begin
        for (int i = 7; i >= 0; i--) begin
          shift_in_bit(d[i]);
          run_len = d[i] ? run_len + 3'd1 : 3'd0;
          if (run_len >= hbs_pkg::STUFF_RUN) begin
            run_len = 3'd0;
            shift_in_bit(1'b0);
            stuffed_zeros++;
          end
        end
      end
      hbs_pkg::CMD_END: begin
        for (int i = 7; i >= 0; i--) begin
          shift_in_bit(hbs_pkg::FLAG_BYTE[i]);
        end
        if (fill != 3'd0) begin
          eb.value = pending;
          eb.last  = 1'b1;
          expected_bytes.push_back(eb);
        end else begin
          eb      = expected_bytes.pop_back();
          eb.last = 1'b1;
          expected_bytes.push_back(eb);
          aligned_closes++;
        end
        frames_closed++;
        clear_encoder();
      end
      default: begin
      end
    endcase
  endtask

  // drive one item, hold it until accepted, then predict its bytes
  task automatic send_item(input logic [1:0] c, input logic [7:0] d);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    data_byte <= d;
    @(posedge clk);
    while (in_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    encode_item(c, d);
  endtask

  function automatic logic [7:0] pick_data_byte();
    logic [7:0] v;
    case ($urandom_range(0, 4))
      0: v = 8'hFF;
      1: v = 8'($urandom | $urandom | $urandom);
      2: v = 8'($urandom_range(0, 255)) & 8'hF8;
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    enc_byte_t eb;
    if (!rst && out_valid && !out_stall) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual out_byte %02h frame_last %0b",
                 $time, out_byte, frame_last);
        errors++;
      end else begin
        eb = expected_bytes.pop_front();
        if (out_byte !== eb.value) begin
          $display("%0t: out_byte: expected %02h, actual %02h", $time, eb.value, out_byte);
          errors++;
        end
        if (frame_last !== eb.last) begin
          $display("%0t: frame_last: expected %0b, actual %0b", $time, eb.last, frame_last);
          errors++;
        end
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_directed_cases();
    send_item(hbs_pkg::CMD_START, 8'hA5);
    send_item(hbs_pkg::CMD_DATA, 8'h00);
    send_item(hbs_pkg::CMD_END, 8'hFF);
    send_item(hbs_pkg::CMD_START, 8'h00);
    send_item(hbs_pkg::CMD_DATA, 8'hFF);
    send_item(hbs_pkg::CMD_END, 8'h00);
    send_item(hbs_pkg::CMD_START, 8'hFF);
    send_item(hbs_pkg::CMD_DATA, 8'h7E);
    send_item(hbs_pkg::CMD_DATA, 8'h0F);
    send_item(hbs_pkg::CMD_DATA, 8'h80);
    send_item(hbs_pkg::CMD_DATA, 8'h1F);
    send_item(hbs_pkg::CMD_DATA, 8'hF8);
    send_item(hbs_pkg::CMD_DATA, 8'hFF);
    send_item(hbs_pkg::CMD_END, 8'h55);
    send_item(hbs_pkg::CMD_DATA, 8'hFF);
    send_item(hbs_pkg::CMD_DATA, 8'h3C);
    send_item(hbs_pkg::CMD_END, 8'hAA);
    send_item(CMD_UNUSED, 8'hFF);
    send_item(hbs_pkg::CMD_START, 8'h01);
    send_item(hbs_pkg::CMD_DATA, 8'hF0);
    send_item(CMD_UNUSED, 8'h00);
    send_item(hbs_pkg::CMD_DATA, 8'h0F);
    send_item(hbs_pkg::CMD_START, 8'hFE);
    send_item(hbs_pkg::CMD_END, 8'h7F);
    send_item(hbs_pkg::CMD_END, 8'h80);
  endtask

  // hold the output long enough that the input side must back up
  task automatic test_output_hold();
    hold_req = 1'b1;
    send_item(hbs_pkg::CMD_START, 8'h00);
    for (int j = 0; j < 20; j++) begin
      send_item(hbs_pkg::CMD_DATA, 8'hFF);
    end
    send_item(hbs_pkg::CMD_END, 8'h00);
  endtask

  task automatic test_random_frames(input int n_items);
    int         sent;
    int         k;
    logic [1:0] c;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        send_item(hbs_pkg::CMD_START, 8'($urandom));
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        for (int j = 0; j < k; j++) begin
          if ($urandom_range(0, 19) == 0) begin
            send_item(CMD_UNUSED, 8'($urandom));
          end
          send_item(hbs_pkg::CMD_DATA, pick_data_byte());
        end
        send_item(hbs_pkg::CMD_END, 8'($urandom));
        sent += k + 2;
      end else begin
        c = 2'($urandom_range(0, 3));
        send_item(c, 8'($urandom));
        if (c != CMD_UNUSED) begin
          sent++;
        end
      end
    end
  endtask

  task automatic test_full_rate();
    quiet = 1'b1;
    test_random_frames(150);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    cmd       = hbs_pkg::CMD_START;
    data_byte = 8'h00;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    errors    = 0;
    clear_encoder();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_output_hold();
    test_random_frames(1150);
    test_full_rate();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d output bytes over %0d closed frames (%0d aligned closes).",
             bytes_checked, frames_closed, aligned_closes);
    $display("Inserted %0d stuffing zeros; input held off for %0d cycles.",
             stuffed_zeros, input_stall_cycles);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
